// ----- src/tile_row_palette_decoder_unit_defines.svh -----
// Assertion macros shared by the tile row palette decoder checkers.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef TILE_ROW_PALETTE_DECODER_UNIT_DEFINES_SVH
`define TILE_ROW_PALETTE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TRPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TRPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/trpd_pkg.sv -----
// Shared types and constants for the tile row palette decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package trpd_pkg;

	localparam int PALETTE_BYTES_DEF = 64;
	localparam int ROW_BYTES         = 8;
	localparam int ROW_PIXELS        = 8;
	localparam int INDEX_W           = 6;
	localparam int CFG_W             = 8;
	localparam logic [15:0] INVALID_COLOR = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_MONO   = 2'd0,
		MODE_COLOR  = 2'd1,
		MODE_COMPAT = 2'd2,
		MODE_COLOR3 = 2'd3
	} color_mode_t;

	typedef enum logic [0:0] {
		REG_COLOR_MODE   = 1'b0,
		REG_MONO_PALETTE = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		KIND_WRITE = 1'b0,
		KIND_ROW   = 1'b1
	} kind_t;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] palette_index;
		logic [7:0]         palette_byte;
		logic [7:0]         low_plane;
		logic [7:0]         high_plane;
		logic [7:0]         attribute;
		logic               tile_valid;
	} in_t;

	typedef struct packed {
		logic [15:0] pixel0;
		logic [15:0] pixel1;
		logic [15:0] pixel2;
		logic [15:0] pixel3;
		logic [15:0] pixel4;
		logic [15:0] pixel5;
		logic [15:0] pixel6;
		logic [15:0] pixel7;
		logic [15:0] color_codes;
		logic        above_sprites;
	} out_t;

	typedef logic [ROW_BYTES-1:0][7:0] row_t;

	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] index;
		logic [7:0]         data;
	} store_wr_t;

	typedef struct packed {
		logic       en;
		logic [2:0] palette;
	} store_rd_t;

endpackage

`default_nettype wire

// ----- src/trpd_store.sv -----
// Palette store: rows of eight bytes, one row per palette, byte writes.
// Per-byte valid flops give the cleared-at-reset contents. Uses trpd_pkg.
`default_nettype none

module trpd_store #(
	parameter int PALETTE_BYTES = trpd_pkg::PALETTE_BYTES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  trpd_pkg::store_wr_t  wr,
	input  trpd_pkg::store_rd_t  rd,
	output trpd_pkg::row_t       row
);
	import trpd_pkg::*;

	localparam int ROWS   = (PALETTE_BYTES + ROW_BYTES - 1) / ROW_BYTES;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

	row_t                          mem [ROWS];
	logic [ROWS-1:0][ROW_BYTES-1:0] vld_q;
	row_t                          data_s1;
	logic [ROW_BYTES-1:0]          mask_s1;

	logic              wr_hit;
	logic [ROW_AW-1:0] wr_row;
	logic [2:0]        wr_byte;
	logic              rd_hit;
	logic [ROW_AW-1:0] rd_row;

	assign wr_hit  = wr.en && (int'(wr.index) < PALETTE_BYTES);
	assign wr_row  = wr.index[3 +: ROW_AW];
	assign wr_byte = wr.index[2:0];
	assign rd_hit  = rd.en && (int'(rd.palette) < ROWS);
	assign rd_row  = rd.palette[ROW_AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_row][wr_byte] <= wr.data;
		end
		if (rd.en) begin
			data_s1 <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			mask_s1 <= '0;
		end else begin
			if (wr_hit) begin
				vld_q[wr_row][wr_byte] <= 1'b1;
			end
			if (rd.en) begin
				mask_s1 <= rd_hit ? vld_q[rd_row] : '0;
			end
		end
	end

	// Bytes never written read as zero.
	always_comb begin
		for (int b = 0; b < ROW_BYTES; b++) begin
			row[b] = mask_s1[b] ? data_s1[b] : 8'h00;
		end
	end

endmodule

`default_nettype wire

// ----- src/trpd_lane.sv -----
// One pixel lane: maps a 2-bit color code to a shade or a palette word.
// Uses trpd_pkg for the row type and the invalid color constant.
`default_nettype none

module trpd_lane (
	input  wire  [1:0]       code,
	input  wire              is_color,
	input  wire              tile_ok,
	input  wire  [7:0]       mono_palette,
	input  trpd_pkg::row_t   row,
	output logic [15:0]      pixel
);
	import trpd_pkg::*;

	logic [1:0] shade;
	logic [7:0] lo_byte;
	logic [7:0] hi_byte;

	assign shade   = mono_palette[{code, 1'b0} +: 2];
	assign lo_byte = row[{code, 1'b0}];
	assign hi_byte = row[{code, 1'b1}];

	always_comb begin
		if (!tile_ok) begin
			pixel = INVALID_COLOR;
		end else if (is_color) begin
			pixel = {hi_byte, lo_byte};
		end else begin
			pixel = {14'd0, shade};
		end
	end

endmodule

`default_nettype wire

// ----- src/tile_row_palette_decoder_unit.sv -----
// Top level of the tile row palette decoder: config registers, row decode,
// palette store, eight pixel lanes and the output register. Uses trpd_pkg.
//
//   port group   handshake          payload
//   in_*         in_valid/in_ready  in_data   (trpd_pkg::in_t)
//   out_*        out_valid/out_ready out_data (trpd_pkg::out_t)
//   cfg_*        cfg_we             cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; a decoded row passes
// through the palette row read, then the lanes into the output register.
// A palette write takes effect at its acceptance edge and yields no result.
// Reset clears the config registers, the valid flags and the store's per-byte valid flops.
// A stalled output holds; up to two rows stay in flight before in_ready drops.
`default_nettype none

module tile_row_palette_decoder_unit #(
	parameter int PALETTE_BYTES = trpd_pkg::PALETTE_BYTES_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  trpd_pkg::in_t            in_data,
	output logic                     out_valid,
	input  wire                      out_ready,
	output trpd_pkg::out_t           out_data,
	input  wire                      cfg_we,
	input  trpd_pkg::reg_idx_t       cfg_index,
	input  wire [trpd_pkg::CFG_W-1:0] cfg_data
);
	import trpd_pkg::*;

	color_mode_t color_mode_q;
	logic [7:0]  mono_palette_q;

	logic        accept;
	logic        dec_acc;
	logic        is_color;
	logic        is_compat;
	logic        flip;
	logic [15:0] codes_d;
	store_wr_t   st_wr;
	store_rd_t   st_rd;
	row_t        row_s1;

	logic        v_s1;
	logic [15:0] codes_s1;
	logic        color_s1;
	logic        tile_ok_s1;
	logic        prio_s1;

	logic        adv;
	logic [ROW_PIXELS-1:0][15:0] pix;
	out_t        out_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q   <= MODE_MONO;
			mono_palette_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR_MODE:   color_mode_q   <= color_mode_t'(cfg_data[1:0]);
				REG_MONO_PALETTE: mono_palette_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign dec_acc  = accept && (in_data.kind == KIND_ROW);

	assign is_color  = color_mode_q != MODE_MONO;
	assign is_compat = color_mode_q == MODE_COMPAT;
	assign flip      = is_color && !is_compat && in_data.attribute[5];

	// Pixel 0 comes from bit 7 unless the row is mirrored.
	always_comb begin
		codes_d = '0;
		for (int p = 0; p < ROW_PIXELS; p++) begin
			if (flip) begin
				codes_d[2*p +: 2] = {in_data.high_plane[p], in_data.low_plane[p]};
			end else begin
				codes_d[2*p +: 2] = {in_data.high_plane[7-p], in_data.low_plane[7-p]};
			end
		end
	end

	assign st_wr.en      = accept && (in_data.kind == KIND_WRITE);
	assign st_wr.index   = in_data.palette_index;
	assign st_wr.data    = in_data.palette_byte;
	assign st_rd.en      = dec_acc;
	assign st_rd.palette = is_compat ? 3'd0 : in_data.attribute[2:0];

	trpd_store #(
		.PALETTE_BYTES(PALETTE_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (st_wr),
		.rd     (st_rd),
		.row    (row_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= dec_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_acc) begin
			codes_s1   <= codes_d;
			color_s1   <= is_color;
			tile_ok_s1 <= in_data.tile_valid;
			prio_s1    <= in_data.attribute[7];
		end
	end

	for (genvar g = 0; g < ROW_PIXELS; g++) begin : g_lane
		trpd_lane u_lane (
			.code         (codes_s1[2*g +: 2]),
			.is_color     (color_s1),
			.tile_ok      (tile_ok_s1),
			.mono_palette (mono_palette_q),
			.row          (row_s1),
			.pixel        (pix[g])
		);
	end

	// Merge lane results into the output register; hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_q.pixel0        <= pix[0];
			out_q.pixel1        <= pix[1];
			out_q.pixel2        <= pix[2];
			out_q.pixel3        <= pix[3];
			out_q.pixel4        <= pix[4];
			out_q.pixel5        <= pix[5];
			out_q.pixel6        <= pix[6];
			out_q.pixel7        <= pix[7];
			out_q.color_codes   <= tile_ok_s1 ? codes_s1 : 16'd0;
			out_q.above_sprites <= tile_ok_s1 && color_s1 && prio_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ----- src/trpd_checker.sv -----
// Port-level checks for the tile row palette decoder, bound to the top level.
// Uses trpd_pkg and the assertion macros of the block's defines header.
`default_nettype none
`include "tile_row_palette_decoder_unit_defines.svh"

module trpd_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       in_valid,
	input wire                       in_ready,
	input trpd_pkg::in_t             in_data,
	input wire                       out_valid,
	input wire                       out_ready,
	input trpd_pkg::out_t            out_data,
	input wire                       cfg_we,
	input trpd_pkg::reg_idx_t        cfg_index,
	input wire [trpd_pkg::CFG_W-1:0] cfg_data
);
	import trpd_pkg::*;

	logic [1:0] pend_q;
	logic [1:0] mode_q;
	logic       dec_acc;
	logic       out_acc;
	logic       out_stall;
	logic       mono_out;
	logic       shade_ok;

	assign dec_acc = in_valid && in_ready && (in_data.kind == KIND_ROW);
	assign out_acc = out_valid && out_ready;

	assign out_stall = out_valid && !out_ready;
	assign mono_out  = out_valid && (mode_q == MODE_MONO) && (out_data.pixel0 != INVALID_COLOR);
	assign shade_ok  = (out_data.pixel0[15:2] == 14'd0) && !out_data.above_sprites;

	// Track rows in flight and the current color mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			mode_q <= MODE_MONO;
		end else begin
			pend_q <= pend_q + 2'(dec_acc) - 2'(out_acc);
			if (cfg_we && (cfg_index == REG_COLOR_MODE)) begin
				mode_q <= cfg_data[1:0];
			end
		end
	end

	`TRPD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled output changed")
	`TRPD_ASSERT_NOW(a_no_phantom, out_valid, pend_q != 2'd0, "result without an accepted row")
	`TRPD_ASSERT_NOW(a_depth, 1'b1, pend_q != 2'd3, "more than two rows in flight")
	`TRPD_ASSERT_NOW(a_mono_shade, mono_out, shade_ok, "monochrome result outside shade range")

endmodule

bind tile_row_palette_decoder_unit trpd_checker u_trpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

`default_nettype wire
